[sv/sacl_pkg.sv]
`default_nettype none

package sacl_pkg;

  // access kinds carried on the opcode field
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_WB_MODE     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ALLOC = 8'd1;

  localparam int unsigned CNT_W   = 32;
  localparam int unsigned STAMP_W = 32;

  // control sequencer
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } sacl_state_e;

  // what one lookup did, from the way logic to the control
  typedef struct packed {
    logic       hit;
    logic       evicted;
    logic       memory_write;
    logic [1:0] mem_writes;
  } sacl_outcome_t;

  // statistics counters
  typedef struct packed {
    logic [CNT_W-1:0] access_total;
    logic [CNT_W-1:0] read_total;
    logic [CNT_W-1:0] read_miss_total;
    logic [CNT_W-1:0] write_total;
    logic [CNT_W-1:0] write_miss_total;
    logic [CNT_W-1:0] eviction_total;
    logic [CNT_W-1:0] memory_write_total;
  } sacl_stats_t;

  // saturating add of a small increment
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                               input logic [1:0] inc);
    logic [CNT_W:0] sum;
    sum = {1'b0, c} + (CNT_W+1)'(inc);
    return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

[sv/sacl_if.sv]
`default_nettype none

// access request channel
interface sacl_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] address;

  modport source (output valid, output opcode, output address, input ready);
  modport sink (input valid, input opcode, input address, output ready);
endinterface

// result channel
interface sacl_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [1:0]  way_used;
  logic        evicted;
  logic        memory_write;
  logic [31:0] access_total;
  logic [31:0] read_total;
  logic [31:0] read_miss_total;
  logic [31:0] write_total;
  logic [31:0] write_miss_total;
  logic [31:0] eviction_total;
  logic [31:0] memory_write_total;

  modport source (output valid, output hit, output way_used, output evicted,
                  output memory_write, output access_total, output read_total,
                  output read_miss_total, output write_total, output write_miss_total,
                  output eviction_total, output memory_write_total, input ready);
  modport sink (input valid, input hit, input way_used, input evicted,
                input memory_write, input access_total, input read_total,
                input read_miss_total, input write_total, input write_miss_total,
                input eviction_total, input memory_write_total, output ready);
endinterface

// configuration write channel
interface sacl_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  reg_index;
  logic [31:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

[sv/sacl_tag_ram.sv]
`default_nettype none

module sacl_tag_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

[sv/sacl_way_logic.sv]
`default_nettype none

module sacl_way_logic import sacl_pkg::*; #(
  parameter int unsigned WAYS  = 4,
  parameter int unsigned TAG_W = 22,
  parameter int unsigned WAY_W = 2,
  parameter int unsigned ROW_W = WAYS * (2 + TAG_W + STAMP_W)
) (
  input  wire logic [ROW_W-1:0]   row_i,
  input  wire logic [TAG_W-1:0]   tag_i,
  input  wire logic               is_write_i,
  input  wire logic               wb_mode_i,
  input  wire logic               write_alloc_i,
  input  wire logic [STAMP_W-1:0] stamp_i,
  output logic      [ROW_W-1:0]   row_o,
  output logic      [WAY_W-1:0]   way_o,
  output sacl_outcome_t           outcome_o
);

  localparam int unsigned ENT_W  = 2 + TAG_W + STAMP_W;
  localparam int unsigned LEAVES = 1 << $clog2(WAYS);

  logic               ent_valid [WAYS];
  logic               ent_dirty [WAYS];
  logic [TAG_W-1:0]   ent_tag   [WAYS];
  logic [STAMP_W-1:0] ent_stamp [WAYS];

  logic [STAMP_W-1:0] node_stamp [2*LEAVES];
  logic [WAY_W-1:0]   node_way   [2*LEAVES];
  logic               node_pres  [2*LEAVES];

  logic             any_hit, any_inv;
  logic [WAY_W-1:0] hit_way, inv_way, lru_way, fill_way;
  logic             alloc, evict, victim_dirty;

  // unpack the set row into ways
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      ent_valid[w] = row_i[w*ENT_W + ENT_W - 1];
      ent_dirty[w] = row_i[w*ENT_W + ENT_W - 2];
      ent_tag[w]   = row_i[w*ENT_W + STAMP_W +: TAG_W];
      ent_stamp[w] = row_i[w*ENT_W +: STAMP_W];
    end
  end

  // tag match and first free way, lowest way first
  always_comb begin
    any_hit = 1'b0;
    hit_way = '0;
    any_inv = 1'b0;
    inv_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (ent_valid[w] && ent_tag[w] == tag_i) begin
        any_hit = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!ent_valid[w]) begin
        any_inv = 1'b1;
        inv_way = WAY_W'(w);
      end
    end
  end

  // lru tree: oldest stamp, ties go to the higher way
  always_comb begin
    node_stamp[0] = '0;
    node_way[0]   = '0;
    node_pres[0]  = 1'b0;
    for (int i = 0; i < LEAVES; i++) begin
      node_pres[LEAVES+i]  = (i < WAYS);
      node_way[LEAVES+i]   = WAY_W'(i);
      node_stamp[LEAVES+i] = '0;
      if (i < WAYS) begin
        node_stamp[LEAVES+i] = ent_stamp[i];
      end
    end
    for (int i = LEAVES - 1; i >= 1; i--) begin
      if (node_pres[2*i+1] &&
          (!node_pres[2*i] || node_stamp[2*i+1] <= node_stamp[2*i])) begin
        node_stamp[i] = node_stamp[2*i+1];
        node_way[i]   = node_way[2*i+1];
      end else begin
        node_stamp[i] = node_stamp[2*i];
        node_way[i]   = node_way[2*i];
      end
      node_pres[i] = node_pres[2*i] | node_pres[2*i+1];
    end
  end

  assign lru_way = node_way[1];

  // policy decisions
  always_comb begin
    alloc        = !any_hit && (!is_write_i || write_alloc_i);
    fill_way     = any_inv ? inv_way : lru_way;
    evict        = alloc && !any_inv;
    victim_dirty = ent_dirty[lru_way];

    outcome_o.hit        = any_hit;
    outcome_o.evicted    = evict;
    outcome_o.mem_writes = 2'(evict && victim_dirty)
                         + 2'(is_write_i && (!wb_mode_i || (!any_hit && !write_alloc_i)));
    outcome_o.memory_write = outcome_o.mem_writes != 2'd0;

    if (any_hit) begin
      way_o = hit_way;
    end else if (alloc) begin
      way_o = fill_way;
    end else begin
      way_o = '0;
    end
  end

  // updated set row
  always_comb begin
    row_o = row_i;
    for (int w = 0; w < WAYS; w++) begin
      if (any_hit && hit_way == WAY_W'(w)) begin
        row_o[w*ENT_W +: STAMP_W] = stamp_i;
        if (is_write_i && wb_mode_i) begin
          row_o[w*ENT_W + ENT_W - 2] = 1'b1;
        end
      end
      if (alloc && fill_way == WAY_W'(w)) begin
        row_o[w*ENT_W + ENT_W - 1]       = 1'b1;
        row_o[w*ENT_W + ENT_W - 2]       = is_write_i && wb_mode_i;
        row_o[w*ENT_W + STAMP_W +: TAG_W] = tag_i;
        row_o[w*ENT_W +: STAMP_W]        = stamp_i;
      end
    end
  end

endmodule

`default_nettype wire

[sv/set_associative_cache_lru.sv]
// Set-associative cache tag model with LRU replacement.
//
// req_i carries one access (opcode 0 read, 1 write, byte address). rsp_o
// returns one result per access: hit, way used, eviction, memory write flag
// and the seven saturating statistics counters as they stand after it.
// cfg_i writes register 0 (write-back on write hit) and register 1
// (allocate on write miss); it is always ready and should only be used
// while no access is in flight.
//
// Each set's ways live in one row of a synchronous memory with one write
// port and one read port. The set row is read in the accept cycle; the
// hit check, LRU pick and row write-back happen in ST_LOOKUP, which waits
// while the output register is full. req_i.ready is low in ST_LOOKUP, so
// a new access is taken only after the row read-modify-write is done.
//
// After reset the memory is swept clear, one set per cycle, before
// req_i.ready first rises; both mode registers reset to 1.
// The finished result waits in an output register: a new access is still
// accepted while rsp_o stalls, but its write-back waits until the register
// frees up.

`default_nettype none

module set_associative_cache_lru import sacl_pkg::*; #(
  parameter int unsigned ADDR_BITS  = 32,
  parameter int unsigned WAYS       = 4,
  parameter int unsigned SETS       = 64,
  parameter int unsigned LINE_BYTES = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sacl_req_if.sink   req_i,
  sacl_rsp_if.source rsp_o,
  sacl_cfg_if.sink   cfg_i
);

  localparam int unsigned EFF_W   = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam int unsigned OFF_W   = $clog2(LINE_BYTES + 1) - 1;
  localparam int unsigned IDX_B   = $clog2(SETS + 1) - 1;
  localparam int unsigned SH_W    = OFF_W + IDX_B;
  localparam int unsigned TAG_W   = (EFF_W > SH_W) ? (EFF_W - SH_W) : 1;
  localparam int unsigned SET_W   = $clog2(SETS);
  localparam int unsigned WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned ROW_W   = WAYS * (2 + TAG_W + STAMP_W);
  localparam logic [31:0] ADDR_MASK = (EFF_W >= 32) ? 32'hFFFF_FFFF
                                                    : ((32'd1 << EFF_W) - 32'd1);
  localparam logic [31:0] IDX_MASK  = (32'd1 << IDX_B) - 32'd1;

  sacl_state_e state_q, state_d;
  logic [SET_W-1:0] clr_cnt_q, clr_cnt_d;

  logic             is_write_q;
  logic [TAG_W-1:0] tag_q;
  logic [SET_W-1:0] set_q;
  logic             wb_mode_q, write_alloc_q;

  sacl_stats_t stats_q, stats_d;
  logic        out_valid_q, out_valid_d;
  logic        out_hit_q, out_evicted_q, out_memw_q;
  logic [1:0]  out_way_q;

  logic [31:0]      addr_m;
  logic [TAG_W-1:0] req_tag;
  logic [SET_W-1:0] req_set;

  logic             req_fire, slot_free, commit;
  logic             mem_we, mem_re;
  logic [SET_W-1:0] mem_waddr;
  logic [ROW_W-1:0] mem_wdata, row_rd, row_upd;

  logic [WAY_W-1:0] way_sel;
  sacl_outcome_t    outcome;

  // address split into set index and tag
  always_comb begin
    addr_m  = req_i.address & ADDR_MASK;
    req_set = SET_W'((addr_m >> OFF_W) & IDX_MASK);
    req_tag = TAG_W'(addr_m >> SH_W);
  end

  assign req_fire  = req_i.valid && req_i.ready;
  assign slot_free = !out_valid_q || rsp_o.ready;

  // next state
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + SET_W'(1);
        if (clr_cnt_q == SET_W'(SETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_i.valid) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // sequencer outputs
  always_comb begin
    req_i.ready = 1'b0;
    commit      = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = set_q;
    mem_wdata   = row_upd;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        req_i.ready = 1'b1;
      end
      ST_LOOKUP: begin
        commit = slot_free;
        mem_we = slot_free;
      end
      default: begin
        req_i.ready = 1'b0;
      end
    endcase
  end

  assign mem_re = req_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // access held during the lookup
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      is_write_q <= (req_i.opcode == OP_WRITE);
      tag_q      <= req_tag;
      set_q      <= req_set;
    end
  end

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_mode_q     <= 1'b1;
      write_alloc_q <= 1'b1;
    end else if (cfg_i.valid) begin
      if (cfg_i.reg_index == CFG_WB_MODE) begin
        wb_mode_q <= cfg_i.wdata[0];
      end
      if (cfg_i.reg_index == CFG_WRITE_ALLOC) begin
        write_alloc_q <= cfg_i.wdata[0];
      end
    end
  end

  // set row memory
  sacl_tag_ram #(
    .DEPTH (SETS),
    .WIDTH (ROW_W)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (req_set),
    .rdata_o (row_rd)
  );

  // hit check, replacement and row update
  sacl_way_logic #(
    .WAYS  (WAYS),
    .TAG_W (TAG_W),
    .WAY_W (WAY_W),
    .ROW_W (ROW_W)
  ) u_way_logic (
    .row_i         (row_rd),
    .tag_i         (tag_q),
    .is_write_i    (is_write_q),
    .wb_mode_i     (wb_mode_q),
    .write_alloc_i (write_alloc_q),
    .stamp_i       (stats_q.access_total),
    .row_o         (row_upd),
    .way_o         (way_sel),
    .outcome_o     (outcome)
  );

  // statistics update
  always_comb begin
    stats_d = stats_q;
    if (commit) begin
      stats_d.access_total       = sat_add(stats_q.access_total, 2'd1);
      stats_d.read_total         = sat_add(stats_q.read_total, 2'(!is_write_q));
      stats_d.read_miss_total    = sat_add(stats_q.read_miss_total,
                                           2'(!is_write_q && !outcome.hit));
      stats_d.write_total        = sat_add(stats_q.write_total, 2'(is_write_q));
      stats_d.write_miss_total   = sat_add(stats_q.write_miss_total,
                                           2'(is_write_q && !outcome.hit));
      stats_d.eviction_total     = sat_add(stats_q.eviction_total, 2'(outcome.evicted));
      stats_d.memory_write_total = sat_add(stats_q.memory_write_total,
                                           outcome.mem_writes);
    end
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stats_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      stats_q     <= stats_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result fields
  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_hit_q     <= outcome.hit;
      out_evicted_q <= outcome.evicted;
      out_memw_q    <= outcome.memory_write;
      out_way_q     <= 2'(way_sel);
    end
  end

  assign rsp_o.valid              = out_valid_q;
  assign rsp_o.hit                = out_hit_q;
  assign rsp_o.way_used           = out_way_q;
  assign rsp_o.evicted            = out_evicted_q;
  assign rsp_o.memory_write       = out_memw_q;
  assign rsp_o.access_total       = stats_q.access_total;
  assign rsp_o.read_total         = stats_q.read_total;
  assign rsp_o.read_miss_total    = stats_q.read_miss_total;
  assign rsp_o.write_total        = stats_q.write_total;
  assign rsp_o.write_miss_total   = stats_q.write_miss_total;
  assign rsp_o.eviction_total     = stats_q.eviction_total;
  assign rsp_o.memory_write_total = stats_q.memory_write_total;

  // no request taken while the memory is being cleared
  a_no_req_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !req_i.ready)
    else $error("request accepted during memory clear");

  // a hit never replaces a line
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |-> !(outcome.hit && outcome.evicted))
    else $error("hit and eviction in one access");

  // a committed lookup returns to idle with a result waiting
  a_commit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> state_q == ST_IDLE && out_valid_q)
    else $error("lookup commit did not complete");

  // access count only moves on a commit
  a_access_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !commit |=> $stable(stats_q.access_total))
    else $error("access count changed without a commit");

endmodule

`default_nettype wire

[verif/sacl_scoreboard.sv]
`default_nettype none

module sacl_scoreboard import sacl_pkg::*; #(
  parameter int unsigned WAYS       = 4,
  parameter int unsigned SETS       = 64,
  parameter int unsigned LINE_BYTES = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sacl_req_if       req_i,
  sacl_rsp_if       rsp_i,
  sacl_cfg_if       cfg_i,
  output int        mismatch_count_o,
  output int        pending_o,
  output int        hit_count_o,
  output int        eviction_count_o
);

  localparam int unsigned OFF_W = $clog2(LINE_BYTES);
  localparam int unsigned SET_W = $clog2(SETS);
  localparam int unsigned TAG_W = 32 - OFF_W - SET_W;
  localparam int unsigned LINES = WAYS * SETS;

  // one predicted result
  typedef struct packed {
    logic        hit;
    logic [1:0]  way_used;
    logic        evicted;
    logic        memory_write;
    sacl_stats_t stats;
  } access_result_t;

  // shadow copy of the tag store and statistics
  logic               line_valid [LINES];
  logic               line_dirty [LINES];
  logic [TAG_W-1:0]   line_tag   [LINES];
  logic [STAMP_W-1:0] line_stamp [LINES];
  sacl_stats_t        tally;
  logic               wb_mode;
  logic               write_alloc;

  access_result_t expected_results [$];

  // scratch for the request being predicted
  access_result_t want;
  int             base;
  int             slot;
  int             fails;
  logic [TAG_W-1:0] tag;
  logic           ev;
  logic           mw;

  // counter that sticks at all ones
  function automatic logic [CNT_W-1:0] bump_sat(input logic [CNT_W-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  // place a line in the set: first free way, else the least recently used one
  function automatic int allocate_line(input int set_base, input logic [TAG_W-1:0] new_tag,
                                       inout logic evicted, inout logic memw);
    int                 victim;
    int                 w;
    logic [STAMP_W-1:0] oldest;
    victim = 0;
    oldest = tally.access_total;
    // ties go to the highest way
    for (w = 0; w < WAYS; w++) begin
      if (oldest >= line_stamp[set_base + w]) begin
        victim = w;
        oldest = line_stamp[set_base + w];
      end
    end
    for (w = 0; w < WAYS; w++) begin
      if (!line_valid[set_base + w]) begin
        line_valid[set_base + w] = 1'b1;
        line_tag[set_base + w]   = new_tag;
        line_stamp[set_base + w] = tally.access_total;
        return w;
      end
    end
    evicted = 1'b1;
    tally.eviction_total = bump_sat(tally.eviction_total);
    if (line_dirty[set_base + victim]) begin
      line_dirty[set_base + victim] = 1'b0;
      tally.memory_write_total = bump_sat(tally.memory_write_total);
      memw = 1'b1;
    end
    line_tag[set_base + victim]   = new_tag;
    line_stamp[set_base + victim] = tally.access_total;
    return victim;
  endfunction

  function automatic int check_field(input string name, input logic [31:0] exp_val,
                                     input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_val, act_val);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // store cleared, both modes on
      for (int i = 0; i < LINES; i++) begin
        line_valid[i] = 1'b0;
        line_dirty[i] = 1'b0;
        line_tag[i]   = '0;
        line_stamp[i] = '0;
      end
      tally            = '0;
      wb_mode          = 1'b1;
      write_alloc      = 1'b1;
      expected_results.delete();
      mismatch_count_o = 0;
      hit_count_o      = 0;
      eviction_count_o = 0;
    end else begin
      // compare a returned result with the oldest prediction
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_results.size() == 0) begin
          $error("result returned with no request pending");
          mismatch_count_o++;
        end else begin
          want  = expected_results.pop_front();
          fails = 0;
          fails += check_field("hit", 32'(want.hit), 32'(rsp_i.hit));
          fails += check_field("way_used", 32'(want.way_used), 32'(rsp_i.way_used));
          fails += check_field("evicted", 32'(want.evicted), 32'(rsp_i.evicted));
          fails += check_field("memory_write", 32'(want.memory_write),
                               32'(rsp_i.memory_write));
          fails += check_field("access_total", want.stats.access_total,
                               rsp_i.access_total);
          fails += check_field("read_total", want.stats.read_total, rsp_i.read_total);
          fails += check_field("read_miss_total", want.stats.read_miss_total,
                               rsp_i.read_miss_total);
          fails += check_field("write_total", want.stats.write_total, rsp_i.write_total);
          fails += check_field("write_miss_total", want.stats.write_miss_total,
                               rsp_i.write_miss_total);
          fails += check_field("eviction_total", want.stats.eviction_total,
                               rsp_i.eviction_total);
          fails += check_field("memory_write_total", want.stats.memory_write_total,
                               rsp_i.memory_write_total);
          mismatch_count_o += fails;
          if (want.hit) hit_count_o++;
          if (want.evicted) eviction_count_o++;
        end
      end

      // mode register writes
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.reg_index == CFG_WB_MODE) begin
          wb_mode = cfg_i.wdata[0];
        end else if (cfg_i.reg_index == CFG_WRITE_ALLOC) begin
          write_alloc = cfg_i.wdata[0];
        end
      end

      // predict the result of an accepted request
      if (req_i.valid && req_i.ready) begin
        base = int'(req_i.address[OFF_W +: SET_W]) * WAYS;
        tag  = req_i.address[31 -: TAG_W];
        want = '0;
        slot = 0;
        ev   = 1'b0;
        mw   = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
          if (!want.hit && line_valid[base + w] && line_tag[base + w] == tag) begin
            want.hit = 1'b1;
            slot     = w;
          end
        end
        if (req_i.opcode == OP_WRITE) begin
          tally.write_total = bump_sat(tally.write_total);
          if (want.hit) begin
            line_stamp[base + slot] = tally.access_total;
            if (wb_mode) begin
              line_dirty[base + slot] = 1'b1;
            end else begin
              tally.memory_write_total = bump_sat(tally.memory_write_total);
              mw = 1'b1;
            end
          end else begin
            tally.write_miss_total = bump_sat(tally.write_miss_total);
            if (write_alloc) begin
              slot = allocate_line(base, tag, ev, mw);
              if (wb_mode) begin
                line_dirty[base + slot] = 1'b1;
              end else begin
                tally.memory_write_total = bump_sat(tally.memory_write_total);
                mw = 1'b1;
              end
            end else begin
              // write goes around the cache, way reported as 0
              tally.memory_write_total = bump_sat(tally.memory_write_total);
              mw = 1'b1;
            end
          end
        end else begin
          tally.read_total = bump_sat(tally.read_total);
          if (want.hit) begin
            line_stamp[base + slot] = tally.access_total;
          end else begin
            tally.read_miss_total = bump_sat(tally.read_miss_total);
            slot = allocate_line(base, tag, ev, mw);
          end
        end
        tally.access_total = bump_sat(tally.access_total);
        want.way_used     = slot[1:0];
        want.evicted      = ev;
        want.memory_write = mw;
        want.stats        = tally;
        expected_results.push_back(want);
      end
    end
    pending_o = expected_results.size();
  end

endmodule

`default_nettype wire

[verif/tb_set_associative_cache_lru.sv]
`default_nettype none

module tb_set_associative_cache_lru import sacl_pkg::*;;

  localparam int WATCHDOG_LIMIT   = 5000;
  localparam int DRAIN_CYCLES     = 8;
  localparam int RANDOM_PER_PHASE = 230;
  localparam int POOL_TAGS        = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'd7;

  logic clk_i;
  logic rst_ni;

  sacl_req_if req_if ();
  sacl_rsp_if rsp_if ();
  sacl_cfg_if cfg_if ();

  int mismatches;
  int outstanding;
  int hits;
  int evictions;

  int          idle_cycles = 0;
  int          stall_left  = 0;
  bit          calm        = 1'b0;
  int          access_count  = 0;
  int          write_count   = 0;
  int          setting_count = 0;
  logic [21:0] tag_pool [POOL_TAGS];

  // write-policy settings for the random phases, extremes included
  logic wb_plan [5] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
  logic wa_plan [5] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1};

  set_associative_cache_lru DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  sacl_scoreboard u_scoreboard (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (req_if),
    .rsp_i            (rsp_if),
    .cfg_i            (cfg_if),
    .mismatch_count_o (mismatches),
    .pending_o        (outstanding),
    .hit_count_o      (hits),
    .eviction_count_o (evictions)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // mostly short gaps, a few long ones, none while calm
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm) return 0;
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] line_addr(input logic [21:0] tag, input logic [5:0] set_idx,
                                            input logic [3:0] offset);
    return {tag, set_idx, offset};
  endfunction

  // result-side backpressure
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      rsp_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      rsp_if.ready <= 1'b1;
      if ($urandom_range(0, 99) < 25) stall_left <= pick_gap();
    end
  end

  // watchdog on cycles with no handshake on any channel
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $error("no request moved for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_set_associative_cache_lru failed");
      $finish;
    end
  end

  // one access request; valid only drops when a gap follows
  task automatic send_access(input logic op, input logic [31:0] addr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.opcode  <= op;
    req_if.address <= addr;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    access_count++;
    if (op == OP_WRITE) write_count++;
  endtask

  // drain the cache, then write both mode registers
  task automatic set_modes(input logic wb, input logic wa, input bit poke_unused);
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    if (poke_unused) begin
      // index outside the register map is ignored
      cfg_if.reg_index <= CFG_UNUSED;
      cfg_if.wdata     <= $urandom();
      @(posedge clk_i);
      while (!cfg_if.ready) @(posedge clk_i);
    end
    cfg_if.reg_index <= CFG_WB_MODE;
    cfg_if.wdata     <= {31'($urandom()), wb};
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.reg_index <= CFG_WRITE_ALLOC;
    cfg_if.wdata     <= {31'($urandom()), wa};
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    setting_count++;
  endtask

  initial begin
    logic [31:0] addr;
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.opcode    = OP_READ;
    req_if.address   = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.reg_index = CFG_WB_MODE;
    cfg_if.wdata     = '0;
    rsp_if.ready     = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: write-back with allocate (reset modes)
    send_access(OP_READ, 32'h0000_0000);
    send_access(OP_READ, 32'hFFFF_FFFF);
    send_access(OP_WRITE, 32'hFFFF_FFF0);
    send_access(OP_READ, 32'h0000_000F);
    for (int t = 1; t <= 3; t++) send_access(OP_WRITE, line_addr(22'(t), 6'd0, 4'd0));
    // set full: clean eviction, then dirty eviction
    send_access(OP_READ, line_addr(22'd4, 6'd0, 4'd0));
    send_access(OP_WRITE, line_addr(22'd5, 6'd0, 4'd8));

    // write-through allocate evicting a dirty line: two memory writes
    set_modes(1'b0, 1'b1, 1'b1);
    send_access(OP_WRITE, line_addr(22'd6, 6'd0, 4'd0));
    send_access(OP_WRITE, line_addr(22'd6, 6'd0, 4'd4));
    send_access(OP_READ, line_addr(22'd3, 6'd0, 4'd0));

    // write miss without allocate
    set_modes(1'b1, 1'b0, 1'b0);
    send_access(OP_WRITE, line_addr(22'h3F_FFFF, 6'd5, 4'd0));
    send_access(OP_READ, line_addr(22'h3F_FFFF, 6'd5, 4'd0));
    send_access(OP_WRITE, line_addr(22'h3F_FFFF, 6'd5, 4'd15));

    // dirty lines from write-back still written out after the mode change
    set_modes(1'b0, 1'b0, 1'b0);
    send_access(OP_WRITE, line_addr(22'd7, 6'd0, 4'd0));
    send_access(OP_READ, line_addr(22'd3, 6'd0, 4'd2));
    send_access(OP_READ, line_addr(22'd8, 6'd0, 4'd0));
    send_access(OP_READ, line_addr(22'd9, 6'd0, 4'd0));

    // random phases, mostly a few hot sets and tags so lines get reused
    for (int p = 0; p < 5; p++) begin
      set_modes(wb_plan[p], wa_plan[p], 1'b0);
      for (int i = 0; i < POOL_TAGS; i++) tag_pool[i] = 22'($urandom());
      if (p == 0) begin
        tag_pool[0] = '0;
        tag_pool[1] = '1;
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n % 50 == 0) calm = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 99) < 75) begin
          addr = line_addr(tag_pool[$urandom_range(0, POOL_TAGS - 1)],
                           6'($urandom_range(0, 3) * 21), 4'($urandom()));
        end else begin
          addr = $urandom();
        end
        send_access(1'($urandom()), addr);
      end
    end
    calm = 1'b0;

    // let every result come back
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("ran %0d accesses (%0d writes) over %0d write-policy settings",
             access_count, write_count, setting_count + 1);
    $display("saw %0d hits and %0d evictions, %0d field mismatches",
             hits, evictions, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_set_associative_cache_lru passed");
    end else begin
      $display("tb_set_associative_cache_lru failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
